@@ design/wfp_pkg.sv @@
package wfp_pkg;

    typedef enum logic [2:0] {
        PH_B0    = 3'd0,
        PH_B1    = 3'd1,
        PH_EXT16 = 3'd2,
        PH_EXT64 = 3'd3,
        PH_KEY   = 3'd4,
        PH_DATA  = 3'd5
    } phase_t;

    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES    = 4'd2;
    localparam logic [3:0] EXT64_BYTES    = 4'd8;
    localparam logic [3:0] KEY_BYTES      = 4'd4;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    localparam int TDATA_W = 88;

    typedef struct packed {
        logic        kind;
        logic        fin_bit;
        logic [2:0]  reserved_bits;
        logic [3:0]  frame_opcode;
        logic        mask_present;
        logic [63:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last;
        logic        length_error;
    } result_t;

endpackage

@@ design/websocket_frame_parser_unit.sv @@
// WebSocket (RFC 6455) frame deframer. Raw stream bytes enter on s_tdata, one
// per transfer, and the block takes one byte every cycle unless m_tready holds
// the output back. A byte is registered in the input stage, and its result is
// registered in the output stage. Header bytes give no result until the header
// is complete (length, extended length and masking key); then one header
// result comes out (m_tuser = 0), followed by one unmasked payload byte per
// input byte (m_tuser = 1). m_tlast marks the final result of a frame: the
// last payload byte, or the header itself for an empty payload or a 64-bit
// length with its top bit set (length_error), in which case the frame is
// dropped and the next byte starts a new header. Extended lengths are read
// most significant byte first. The combinational parse step, dominated by the
// 64-bit remaining-count decrement, sets the clock rate.
module websocket_frame_parser_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] data_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [0] fin_bit, [3:1] reserved_bits, [7:4] frame_opcode, [8] mask_present,
    // [72:9] payload_length, [80:73] payload_byte, [81] length_error, rest zero
    output logic [wfp_pkg::TDATA_W-1:0] m_tdata,
    output logic                        m_tuser,   // [0] kind
    output logic                        m_tlast
);

    import wfp_pkg::*;

    logic       advance;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       fire;
    logic       res_valid;
    result_t    res;

    assign fire = in_valid && advance;

    wfp_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    wfp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .in_byte   (in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    wfp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ design/wfp_in_stage.sv @@
module wfp_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       advance,
    output logic       in_valid,
    output logic [7:0] in_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    assign s_tready = !valid_reg || advance;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

endmodule

@@ design/wfp_parser.sv @@
module wfp_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  logic [7:0]       in_byte,
    output logic             res_valid,
    output wfp_pkg::result_t res
);

    import wfp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  hdr_reg, hdr_next;
    logic        mask_reg, mask_next;
    logic [63:0] len_reg, len_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] remain_reg, remain_next;
    logic [1:0]  kidx_reg, kidx_next;

    logic [3:0]  cnt_inc;
    logic [63:0] len_shift;
    logic [7:0]  key_byte;
    logic        emit_hdr;
    logic        hdr_bad;
    logic        hdr_empty;

    assign cnt_inc   = cnt_reg + 4'd1;
    assign len_shift = {len_reg[55:0], in_byte};

    always_comb begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next  = phase_reg;
        hdr_next    = hdr_reg;
        mask_next   = mask_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        remain_next = remain_reg;
        kidx_next   = kidx_reg;
        emit_hdr    = 1'b0;
        res_valid   = 1'b0;

        res.kind           = KIND_HEADER;
        res.fin_bit        = hdr_reg[7];
        res.reserved_bits  = hdr_reg[6:4];
        res.frame_opcode   = hdr_reg[3:0];
        res.mask_present   = mask_reg;
        res.payload_length = 64'd0;
        res.payload_byte   = 8'd0;
        res.last           = 1'b0;
        res.length_error   = 1'b0;

        unique case (phase_reg)
            PH_B0: begin
                hdr_next   = in_byte;
                mask_next  = 1'b0;
                key_next   = 32'd0;
                len_next   = 64'd0;
                cnt_next   = 4'd0;
                phase_next = PH_B1;
            end
            PH_B1: begin
                mask_next = in_byte[7];
                res.mask_present = in_byte[7];
                cnt_next  = 4'd0;
                len_next  = 64'd0;
                if (in_byte[6:0] == LEN_CODE_EXT16) begin
                    phase_next = PH_EXT16;
                end else if (in_byte[6:0] == LEN_CODE_EXT64) begin
                    phase_next = PH_EXT64;
                end else begin
                    len_next = {57'd0, in_byte[6:0]};
                    if (in_byte[7]) begin
                        phase_next = PH_KEY;
                    end else begin
                        emit_hdr = 1'b1;
                    end
                end
            end
            PH_EXT16, PH_EXT64: begin
                len_next = len_shift;
                cnt_next = cnt_inc;
                if (cnt_inc >= ((phase_reg == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
                    if (mask_reg) begin
                        cnt_next   = 4'd0;
                        phase_next = PH_KEY;
                    end else begin
                        emit_hdr = 1'b1;
                    end
                end
            end
            PH_KEY: begin
                key_next = {key_reg[23:0], in_byte};
                cnt_next = cnt_inc;
                if (cnt_inc >= KEY_BYTES) begin
                    emit_hdr = 1'b1;
                end
            end
            PH_DATA: begin
                kidx_next          = kidx_reg + 2'd1;
                remain_next        = remain_reg - 64'd1;
                res_valid          = 1'b1;
                res.kind           = KIND_PAYLOAD;
                res.payload_byte   = in_byte ^ key_byte;
                if (remain_reg == 64'd1) begin
                    res.last   = 1'b1;
                    phase_next = PH_B0;
                end
            end
            default: begin
                phase_next = PH_B0;
            end
        endcase

        hdr_bad   = len_next[63];
        hdr_empty = (len_next == 64'd0);
        if (emit_hdr) begin
            res_valid          = 1'b1;
            res.kind           = KIND_HEADER;
            res.payload_length = len_next;
            res.length_error   = hdr_bad;
            if (hdr_bad || hdr_empty) begin
                res.last   = 1'b1;
                phase_next = PH_B0;
            end else begin
                remain_next = len_next;
                kidx_next   = 2'd0;
                phase_next  = PH_DATA;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_B0;
            hdr_reg    <= 8'd0;
            mask_reg   <= 1'b0;
            len_reg    <= 64'd0;
            cnt_reg    <= 4'd0;
            key_reg    <= 32'd0;
            remain_reg <= 64'd0;
            kidx_reg   <= 2'd0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            hdr_reg    <= hdr_next;
            mask_reg   <= mask_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            key_reg    <= key_next;
            remain_reg <= remain_next;
            kidx_reg   <= kidx_next;
        end
    end

endmodule

@@ design/wfp_out_stage.sv @@
module wfp_out_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          fire,
    input  logic                          res_valid,
    input  wfp_pkg::result_t              res,
    output logic                          advance,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wfp_pkg::TDATA_W-1:0]   m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    import wfp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign advance  = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {6'd0,
                       res_reg.length_error,
                       res_reg.payload_byte,
                       res_reg.payload_length,
                       res_reg.mask_present,
                       res_reg.frame_opcode,
                       res_reg.reserved_bits,
                       res_reg.fin_bit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= fire && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

@@ test/websocket_frame_parser_unit_tb.sv @@
module websocket_frame_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wfp_pkg::*;

    localparam int unsigned RANDOM_BYTES = 1700;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned TAIL_CYCLES  = 10;
    localparam int unsigned PRINT_LIMIT  = 40;

    typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;
    typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    websocket_frame_parser_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // deframer state mirror
    phase_t      st_phase = PH_B0;
    logic [7:0]  st_hdr0  = '0;
    logic        st_mask  = 1'b0;
    logic [63:0] st_len   = '0;
    logic [3:0]  st_cnt   = '0;
    logic [31:0] st_key   = '0;
    logic [63:0] st_remain = '0;
    logic [1:0]  st_kidx  = '0;

    result_t     pending_results[$];
    int unsigned mismatch_count = 0;
    int unsigned bytes_sent     = 0;
    int unsigned burst_left     = 0;
    int unsigned stall_count    = 0;
    logic        rx_hold_req    = 1'b0;

    task automatic deframe_byte(input logic [7:0] b);
        result_t    r;
        logic       produce;
        logic       header_done;
        logic [7:0] kb;
        r           = '0;
        produce     = 1'b0;
        header_done = 1'b0;
        case (st_phase)
            PH_B0: begin
                st_hdr0  = b;
                st_mask  = 1'b0;
                st_key   = '0;
                st_len   = '0;
                st_cnt   = '0;
                st_phase = PH_B1;
            end
            PH_B1: begin
                st_mask = b[7];
                st_cnt  = '0;
                st_len  = '0;
                if (b[6:0] == LEN_CODE_EXT16) begin
                    st_phase = PH_EXT16;
                end else if (b[6:0] == LEN_CODE_EXT64) begin
                    st_phase = PH_EXT64;
                end else begin
                    st_len      = 64'(b[6:0]);
                    header_done = 1'b1;
                end
            end
            PH_EXT16, PH_EXT64: begin
                st_len = {st_len[55:0], b};
                st_cnt = st_cnt + 4'd1;
                if (st_cnt >= ((st_phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
                    header_done = 1'b1;
                end
            end
            PH_KEY: begin
                st_key = {st_key[23:0], b};
                st_cnt = st_cnt + 4'd1;
                if (st_cnt >= KEY_BYTES) begin
                    produce = 1'b1;
                end
            end
            PH_DATA: begin
                kb             = st_key[8*(3-st_kidx) +: 8];
                st_kidx        = st_kidx + 2'd1;
                st_remain      = st_remain - 64'd1;
                produce        = 1'b1;
                r.kind         = KIND_PAYLOAD;
                r.payload_byte = b ^ kb;
                r.last         = (st_remain == 64'd0);
                if (r.last) begin
                    st_phase = PH_B0;
                end
            end
            default: begin
                st_phase = PH_B0;
            end
        endcase
        // key still to come for masked frames
        if (header_done) begin
            if (st_mask) begin
                st_cnt   = '0;
                st_phase = PH_KEY;
            end else begin
                produce = 1'b1;
            end
        end
        if (produce && r.kind == KIND_HEADER) begin
            r.payload_length = st_len;
            r.length_error   = st_len[63];
            if (st_len[63] || st_len == 64'd0) begin
                r.last   = 1'b1;
                st_phase = PH_B0;
            end else begin
                st_remain = st_len;
                st_kidx   = '0;
                st_phase  = PH_DATA;
            end
        end
        if (produce) begin
            r.fin_bit       = st_hdr0[7];
            r.reserved_bits = st_hdr0[6:4];
            r.frame_opcode  = st_hdr0[3:0];
            r.mask_present  = st_mask;
            pending_results.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transfer", 64'(m_tdata), '0);
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 64'(m_tuser), 64'(want.kind));
                check_field("fin_bit", 64'(m_tdata[0]), 64'(want.fin_bit));
                check_field("reserved_bits", 64'(m_tdata[3:1]), 64'(want.reserved_bits));
                check_field("frame_opcode", 64'(m_tdata[7:4]), 64'(want.frame_opcode));
                check_field("mask_present", 64'(m_tdata[8]), 64'(want.mask_present));
                check_field("payload_length", m_tdata[72:9], want.payload_length);
                check_field("payload_byte", 64'(m_tdata[80:73]), 64'(want.payload_byte));
                check_field("length_error", 64'(m_tdata[81]), 64'(want.length_error));
                check_field("pad bits", 64'(m_tdata[TDATA_W-1:82]), '0);
                check_field("last", 64'(m_tlast), 64'(want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        rx_mode_t    mode;
        int unsigned seg_left;
        mode     = RX_ALWAYS;
        seg_left = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = rx_mode_t'($urandom_range(0, 3));
                    seg_left = $urandom_range(20, 300);
                end
                seg_left--;
                case (mode)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom);
                    RX_MOSTLY: m_tready <= ($urandom_range(0, 9) != 0);
                    default:   m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        bytes_sent++;
        deframe_byte(b);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic send_frame(input logic [7:0] hdr0, input logic masked,
                              input len_form_t form, input logic [63:0] len,
                              input logic [31:0] key);
        send_byte(hdr0);
        case (form)
            LEN_SHORT: send_byte({masked, len[6:0]});
            LEN_EXT16: begin
                send_byte({masked, LEN_CODE_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default: begin
                send_byte({masked, LEN_CODE_EXT64});
                for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
            end
        endcase
        if (masked) begin
            for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
        end
        // a flagged length drops the frame, no payload follows
        if (!len[63]) begin
            for (longint unsigned n = 0; n < len; n++) send_byte(8'($urandom));
        end
    endtask

    task automatic send_random_frame();
        int unsigned pick;
        len_form_t   form;
        logic [63:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            form = LEN_SHORT;
            len  = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 125))
                                               : 64'($urandom_range(0, 12));
        end else if (pick < 85) begin
            form = LEN_EXT16;
            len  = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(126, 300))
                                               : 64'($urandom_range(0, 40));
        end else if (pick < 95) begin
            form = LEN_EXT64;
            len  = 64'($urandom_range(0, 30));
        end else begin
            form = LEN_EXT64;
            len  = {1'b1, 31'($urandom), 32'($urandom)};
        end
        send_frame(8'($urandom), 1'($urandom), form, len, $urandom);
    endtask

    task automatic test_directed_frames();
        send_frame(8'hFF, 1'b1, LEN_SHORT, 64'd0, 32'hFFFF_FFFF);
        send_frame(8'h82, 1'b0, LEN_EXT16, 64'd1, '0);
        send_frame(8'h71, 1'b0, LEN_EXT64, 64'h8000_0000_0000_0000, '0);
        send_frame(8'h8A, 1'b1, LEN_SHORT, 64'd2, 32'h00FF_A55A);
        send_frame(8'h00, 1'b0, LEN_EXT64, 64'd3, '0);
        wait_for_results();
    endtask

    task automatic test_output_hold();
        rx_hold_req = 1'b1;
        send_frame(8'h82, 1'b1, LEN_EXT16, 64'd200, $urandom);
        wait_for_results();
    endtask

    task automatic test_random_frames();
        int unsigned frames;
        int unsigned target;
        frames = 0;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            send_random_frame();
            frames++;
            if (frames % 30 == 0) begin
                wait_for_results();
            end
        end
        wait_for_results();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_frames();
        test_output_hold();
        test_random_frames();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            report_mismatch("results missing", 64'(pending_results.size()), '0);
        end
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
